@@ rtl/core/penalty_sphere_contact_force_defines.svh @@
// ----------------------------------------------------------------------------
// Penalty sphere contact: assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef PENALTY_SPHERE_CONTACT_FORCE_DEFINES_SVH
`define PENALTY_SPHERE_CONTACT_FORCE_DEFINES_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("penalty_sphere_contact_force: check failed");

// next-cycle implication
`define PSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("penalty_sphere_contact_force: check failed");

`endif

@@ rtl/core/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// Penalty sphere contact: package
// Constants, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

  localparam int DIMS = 3;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_CENTER_Z    = 3'd2;
  localparam logic [2:0] REG_RADIUS      = 3'd3;
  localparam logic [2:0] REG_STIFFNESS   = 3'd4;
  localparam logic [2:0] REG_FORCE_SCALE = 3'd5;

  localparam logic [30:0] FORCE_SCALE_RST = 31'd65536;
  localparam logic [4:0]  ROOT_STEPS_M1   = 5'd31;
  localparam logic [4:0]  DIV_STEPS_M1    = 5'd30;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_PK,
    OP_PK_TAKE,
    OP_G_LO,
    OP_G_HI,
    OP_G_SUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_M0,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic skip_force;
  } status_t;

endpackage

@@ rtl/core/psc_in_if.sv @@
// ----------------------------------------------------------------------------
// Penalty sphere contact: node channel
// Valid/ready channel carrying one contact node per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [31:0] ref_z;
  logic signed [31:0] disp_x;
  logic signed [31:0] disp_y;
  logic signed [31:0] disp_z;
  logic               last_node;

  modport source (output valid, ref_x, ref_y, ref_z, disp_x, disp_y, disp_z, last_node,
                  input ready);
  modport sink   (input valid, ref_x, ref_y, ref_z, disp_x, disp_y, disp_z, last_node,
                  output ready);
endinterface

@@ rtl/core/psc_out_if.sv @@
// ----------------------------------------------------------------------------
// Penalty sphere contact: result channel
// Valid/ready channel carrying one contact result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic        [30:0] distance;
  logic               in_contact;
  logic        [30:0] max_penetration;
  logic               last_result;

  modport source (output valid, force_x, force_y, force_z, distance, in_contact,
                  max_penetration, last_result, input ready);
  modport sink   (input valid, force_x, force_y, force_z, distance, in_contact,
                  max_penetration, last_result, output ready);
endinterface

@@ rtl/core/psc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Penalty sphere contact: controller
// Sequences the shared multiplier, root and divider steps for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_ctrl import psc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_RINIT, S_ROOT, S_PK, S_PKT, S_GLO,
    S_GHI, S_GSUM, S_DINIT, S_DIV, S_M0, S_M1, S_M2, S_M3, S_DONE
  } state_t;

  state_t     state_r;
  logic [4:0] cnt_r;
  logic       out_valid_r;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_SQ0:   cmd.op = OP_SQ0;
      S_SQ1:   cmd.op = OP_SQ1;
      S_SQ2:   cmd.op = OP_SQ2;
      S_SQ3:   cmd.op = OP_SQ3;
      S_RINIT: cmd.op = OP_ROOT_INIT;
      S_ROOT:  cmd.op = OP_ROOT_STEP;
      S_PK:    cmd.op = OP_PK;
      S_PKT:   cmd.op = OP_PK_TAKE;
      S_GLO:   cmd.op = OP_G_LO;
      S_GHI:   cmd.op = OP_G_HI;
      S_GSUM:  cmd.op = OP_G_SUM;
      S_DINIT: cmd.op = OP_DIV_INIT;
      S_DIV:   cmd.op = OP_DIV_STEP;
      S_M0:    cmd.op = OP_M0;
      S_M1:    cmd.op = OP_M1;
      S_M2:    cmd.op = OP_M2;
      S_M3:    cmd.op = OP_M3;
      S_DONE:  cmd.op = slot_free ? OP_RESULT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE && slot_free) ? 1'b1 : (out_valid_r && !out_ready);
      case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_SQ0;
        S_SQ0:   state_r <= S_SQ1;
        S_SQ1:   state_r <= S_SQ2;
        S_SQ2:   state_r <= S_SQ3;
        S_SQ3:   state_r <= S_RINIT;
        S_RINIT: begin
          cnt_r   <= ROOT_STEPS_M1;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) state_r <= S_PK;
        end
        S_PK:    state_r <= status.skip_force ? S_DONE : S_PKT;
        S_PKT:   state_r <= S_GLO;
        S_GLO:   state_r <= S_GHI;
        S_GHI:   state_r <= S_GSUM;
        S_GSUM:  state_r <= S_DINIT;
        S_DINIT: begin
          cnt_r   <= DIV_STEPS_M1;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) state_r <= S_M0;
        end
        S_M0:    state_r <= S_M1;
        S_M1:    state_r <= S_M2;
        S_M2:    state_r <= S_M3;
        S_M3:    state_r <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/psc_dp.sv @@
// ----------------------------------------------------------------------------
// Penalty sphere contact: datapath
// Registers, shared multiplier, bit-serial root, three divider lanes, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_dp import psc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] ref_x,
  input  logic signed [31:0] ref_y,
  input  logic signed [31:0] ref_z,
  input  logic signed [31:0] disp_x,
  input  logic signed [31:0] disp_y,
  input  logic signed [31:0] disp_z,
  input  logic               last_node,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic [30:0]        distance,
  output logic               in_contact,
  output logic [30:0]        max_penetration,
  output logic               last_result
);

  localparam logic USE_Z = (DIMS >= 3);

  logic signed [31:0] center_r [3];
  logic [30:0] radius_r, stiff_r, fscale_r, max_r;

  logic [30:0] mag_r [3];
  logic [2:0]  sign_r;
  logic        far_r, last_r;
  logic [63:0] prod_r, sum_r, rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r, g_r;
  logic [45:0] pk_r;
  logic [53:0] glo_r;
  logic [31:0] drem_r [3];
  logic [2:0]  dbit_r;
  logic [30:0] q_r [3];
  logic [31:0] force_r [3];

  logic signed [31:0] rin [3];
  logic signed [31:0] din [3];
  logic signed [33:0] v_c [3];
  logic [33:0] a_c [3];
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [35:0] remsh, trial, rdiff;
  logic        rge;
  logic        contact_c;
  logic [30:0] pen_c, max_nxt;
  logic [76:0] gfull;

  function automatic logic [31:0] sat_force(input logic [63:0] p, input logic neg);
    logic [32:0] m;
    logic [31:0] mm;
    m = p[62:30];
    if (neg) begin
      mm = (m > 33'h080000000) ? 32'h80000000 : m[31:0];
      return 32'd0 - mm;
    end
    return (m > 33'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
  endfunction

  assign rin[0] = ref_x;
  assign rin[1] = ref_y;
  assign rin[2] = ref_z;
  assign din[0] = disp_x;
  assign din[1] = disp_y;
  assign din[2] = disp_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_c[i] = 34'(rin[i]) + 34'(din[i]) - 34'(center_r[i]);
      a_c[i] = v_c[i][33] ? 34'(-v_c[i]) : v_c[i];
      if (i == 2 && !USE_Z) begin
        v_c[i] = '0;
        a_c[i] = '0;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = cmd.op inside {OP_SQ0, OP_SQ1, OP_SQ2, OP_PK, OP_G_LO, OP_G_HI,
                            OP_M0, OP_M1, OP_M2};
    case (cmd.op)
      OP_SQ0: begin mul_a = {1'b0, mag_r[0]}; mul_b = {1'b0, mag_r[0]}; end
      OP_SQ1: begin mul_a = {1'b0, mag_r[1]}; mul_b = {1'b0, mag_r[1]}; end
      OP_SQ2: begin mul_a = {1'b0, mag_r[2]}; mul_b = {1'b0, mag_r[2]}; end
      OP_PK:  begin mul_a = {1'b0, pen_c};    mul_b = {1'b0, stiff_r};  end
      OP_G_LO: begin mul_a = {9'b0, pk_r[22:0]};  mul_b = {1'b0, fscale_r}; end
      OP_G_HI: begin mul_a = {9'b0, pk_r[45:23]}; mul_b = {1'b0, fscale_r}; end
      OP_M0:  begin mul_a = {1'b0, q_r[0]}; mul_b = g_r; end
      OP_M1:  begin mul_a = {1'b0, q_r[1]}; mul_b = g_r; end
      OP_M2:  begin mul_a = {1'b0, q_r[2]}; mul_b = g_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign remsh = {rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign rge   = (remsh >= trial);
  assign rdiff = remsh - trial;

  assign contact_c = !far_r && (root_r < {1'b0, radius_r});
  assign pen_c     = radius_r - root_r[30:0];
  assign max_nxt   = (contact_c && pen_c > max_r) ? pen_c : max_r;
  assign gfull     = {23'b0, glo_r} + {prod_r[53:0], 23'b0};

  assign status.skip_force = !contact_c || (root_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      radius_r    <= '0;
      stiff_r     <= '0;
      fscale_r    <= FORCE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:    center_r[0] <= cfg_wdata;
        REG_CENTER_Y:    center_r[1] <= cfg_wdata;
        REG_CENTER_Z:    center_r[2] <= cfg_wdata;
        REG_RADIUS:      radius_r    <= cfg_wdata[30:0];
        REG_STIFFNESS:   stiff_r     <= cfg_wdata[30:0];
        REG_FORCE_SCALE: fscale_r    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (cmd.op == OP_RESULT) begin
      max_r <= last_r ? '0 : max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= 64'(mul_a * mul_b);
    end
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i]   <= a_c[i][30:0];
          sign_r[i]  <= v_c[i][33];
          force_r[i] <= '0;
        end
        far_r  <= (|a_c[0][33:31]) || (|a_c[1][33:31]) || (|a_c[2][33:31]);
        last_r <= last_node;
      end
      OP_SQ1: sum_r <= prod_r;
      OP_SQ2: sum_r <= sum_r + prod_r;
      OP_SQ3: sum_r <= sum_r + prod_r;
      OP_ROOT_INIT: begin
        rem_r  <= '0;
        root_r <= '0;
        rad_r  <= sum_r;
      end
      OP_ROOT_STEP: begin
        rem_r  <= rge ? rdiff[33:0] : remsh[33:0];
        root_r <= {root_r[30:0], rge};
        rad_r  <= {rad_r[61:0], 2'b00};
      end
      OP_PK_TAKE: pk_r  <= prod_r[61:16];
      OP_G_HI:    glo_r <= prod_r[53:0];
      OP_G_SUM:   g_r   <= (|gfull[76:48]) ? 32'hFFFFFFFF : gfull[47:16];
      OP_DIV_INIT: begin
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= {2'b00, mag_r[i][30:1]};
          dbit_r[i] <= mag_r[i][0];
          q_r[i]    <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < 3; i++) begin
          logic [32:0] t;
          logic [32:0] td;
          t  = {drem_r[i], dbit_r[i]};
          td = t - {1'b0, root_r};
          if (t >= {1'b0, root_r}) begin
            drem_r[i] <= td[31:0];
            q_r[i]    <= {q_r[i][29:0], 1'b1};
          end else begin
            drem_r[i] <= t[31:0];
            q_r[i]    <= {q_r[i][29:0], 1'b0};
          end
          dbit_r[i] <= 1'b0;
        end
      end
      OP_M1: force_r[0] <= sat_force(prod_r, sign_r[0]);
      OP_M2: force_r[1] <= sat_force(prod_r, sign_r[1]);
      OP_M3: force_r[2] <= sat_force(prod_r, sign_r[2]);
      OP_RESULT: begin
        force_x         <= force_r[0];
        force_y         <= force_r[1];
        force_z         <= force_r[2];
        distance        <= (far_r || root_r[31]) ? 31'h7FFFFFFF : root_r[30:0];
        in_contact      <= contact_c;
        max_penetration <= max_nxt;
        last_result     <= last_r;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/penalty_sphere_contact_force.sv @@
// Penalty contact against a rigid sphere, one node per item, signed Q16.16.
// One item is in work at a time. A node that does not touch the sphere, or
// lies at its centre, skips the force steps and raises its result sooner than
// a node in contact. The next item is taken once the finished result has
// moved into the output register, which may wait for the previous result to
// leave it. An item's run time is set by the bit-serial square root and the
// three parallel restoring divider lanes, with one shared 32x32 multiplier
// between them.
// A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
// Penalty sphere contact: top level
// Channel ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "penalty_sphere_contact_force_defines.svh"

module penalty_sphere_contact_force import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  psc_in_if.sink      in_ch,
  psc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  psc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .ref_x           (in_ch.ref_x),
    .ref_y           (in_ch.ref_y),
    .ref_z           (in_ch.ref_z),
    .disp_x          (in_ch.disp_x),
    .disp_y          (in_ch.disp_y),
    .disp_z          (in_ch.disp_z),
    .last_node       (in_ch.last_node),
    .force_x         (out_ch.force_x),
    .force_y         (out_ch.force_y),
    .force_z         (out_ch.force_z),
    .distance        (out_ch.distance),
    .in_contact      (out_ch.in_contact),
    .max_penetration (out_ch.max_penetration),
    .last_result     (out_ch.last_result)
  );

  `PSC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `PSC_ASSERT_IMP(a_no_contact_no_force, clk, rst_n, out_ch.valid && !out_ch.in_contact,
    out_ch.force_x == 0 && out_ch.force_y == 0 && out_ch.force_z == 0)
  `PSC_ASSERT_IMP(a_contact_sets_max, clk, rst_n, out_ch.valid && out_ch.in_contact,
    out_ch.max_penetration != 0)

endmodule
